[rtl/gdu_pkg.sv]
// Shared types and constants for the gain and distortion upmixer.
// Used by gdu_chan and gain_distortion_upmixer; depends on nothing else.
package gdu_pkg;

    // Default sample width in bits, fraction format Q0.(SAMPLE_BITS-1).
    localparam int GDU_SAMPLE_BITS = 32;

    // Number of register stages in one channel pipeline.
    localparam int GDU_STAGES = 6;

    // Port field widths.
    localparam int GDU_FIELD_BITS = 32;
    localparam int GDU_COUNT_BITS = 3;
    localparam int GDU_IN_BITS    = 2 * GDU_FIELD_BITS;
    localparam int GDU_OUT_RAW    = 6 * GDU_FIELD_BITS + GDU_COUNT_BITS;
    localparam int GDU_OUT_BITS   = ((GDU_OUT_RAW + 7) / 8) * 8;

    // Curve thresholds and offsets as Q0.31 fractions.
    localparam logic [31:0] GDU_Q31_EIGHTH  = 32'd268435456;
    localparam logic [31:0] GDU_Q31_QUARTER = 32'd536870912;
    localparam logic [31:0] GDU_Q31_THIRD   = 32'd715827883;
    localparam logic [31:0] GDU_Q31_TWELFTH = 32'd178956971;
    localparam logic [31:0] GDU_Q31_SIXTH   = 32'd357913941;

    // Register reset values.
    localparam logic [31:0] GDU_RESET_LIN_GAIN = 32'd1354970579;
    localparam logic [31:0] GDU_RESET_DRV_GAIN = 32'd1073741824;

    // Configuration register indexes.
    localparam logic [1:0] GDU_REG_MODE     = 2'd0;
    localparam logic [1:0] GDU_REG_CURVE    = 2'd1;
    localparam logic [1:0] GDU_REG_LIN_GAIN = 2'd2;
    localparam logic [1:0] GDU_REG_DRV_GAIN = 2'd3;

    typedef enum logic [1:0] {
        MODE_STEREO   = 2'd0,
        MODE_QUAD     = 2'd1,
        MODE_SURROUND = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        CURVE_HARD = 2'd0,
        CURVE_SOFT = 2'd1,
        CURVE_FULL = 2'd2,
        CURVE_HALF = 2'd3
    } curve_t;

    localparam logic [2:0] GDU_COUNT_STEREO   = 3'd2;
    localparam logic [2:0] GDU_COUNT_QUAD     = 3'd4;
    localparam logic [2:0] GDU_COUNT_SURROUND = 3'd6;

endpackage

[rtl/gdu_chan.sv]
// One channel of the upmixer datapath: linear gain, drive gain and curve.
// Six register stages, each loaded by its own enable; uses gdu_pkg.
module gdu_chan #(
    parameter int SAMPLE_BITS = gdu_pkg::GDU_SAMPLE_BITS
) (
    input  logic                              clk,
    input  logic [gdu_pkg::GDU_STAGES-1:0]    load,
    input  gdu_pkg::curve_t                   curve,
    input  logic signed [SAMPLE_BITS-1:0]     lin_gain,
    input  logic signed [SAMPLE_BITS-1:0]     drv_gain,
    input  logic signed [SAMPLE_BITS-1:0]     sample,
    output logic signed [SAMPLE_BITS-1:0]     gained,
    output logic signed [SAMPLE_BITS-1:0]     shaped
);
    import gdu_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int PB = 2 * SB;
    localparam int WB = SB + 6;
    localparam int QS = 32 - SB;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    localparam logic signed [SB-1:0] C_EIGHTH  = SB'(GDU_Q31_EIGHTH >> QS);
    localparam logic signed [SB-1:0] C_TWELFTH = SB'(GDU_Q31_TWELFTH >> QS);
    localparam logic signed [SB-1:0] C_SIXTH   = SB'(GDU_Q31_SIXTH >> QS);

    localparam logic signed [WB-1:0] W_QUARTER = WB'(GDU_Q31_QUARTER >> QS);
    localparam logic signed [WB-1:0] W_THIRD   = WB'(GDU_Q31_THIRD >> QS);
    localparam logic signed [WB-1:0] W_MAX     = WB'(S_MAX);
    localparam logic signed [WB-1:0] W_MIN     = -W_MAX - WB'(1);

    // Product shifted right by SB-1 and saturated to the sample range.
    function automatic logic signed [SB-1:0] scale_sat(input logic signed [PB-1:0] p);
        logic signed [SB-1:0] res;
        if (p[PB-1] == p[PB-2])
            res = p[PB-2:SB-1];
        else if (p[PB-1])
            res = S_MIN;
        else
            res = S_MAX;
        return res;
    endfunction

    // Multiply by four with saturation.
    function automatic logic signed [SB-1:0] times4(input logic signed [SB-1:0] x);
        logic signed [SB-1:0] res;
        if (x[SB-1:SB-3] == 3'b000 || x[SB-1:SB-3] == 3'b111)
            res = {x[SB-3:0], 2'b00};
        else if (x[SB-1])
            res = S_MIN;
        else
            res = S_MAX;
        return res;
    endfunction

    logic signed [PB-1:0] p1_reg;
    logic signed [SB-1:0] l2_reg;
    logic signed [PB-1:0] p3_reg;
    logic signed [SB-1:0] l3_reg;
    logic signed [SB-1:0] v4_reg;
    logic signed [SB-1:0] l4_reg;
    logic        [SB-1:0] sq5_reg;
    logic signed [SB-1:0] v5_reg;
    logic signed [SB-1:0] l5_reg;
    logic signed [SB-1:0] s6_reg;
    logic signed [SB-1:0] l6_reg;

    logic signed [PB-1:0] sq_full;
    logic signed [SB-1:0] s6_next;
    logic signed [WB-1:0] vw;
    logic signed [WB-1:0] sqw;
    logic signed [WB-1:0] w_knee;
    logic signed [SB-1:0] w_sat;
    logic signed [SB-1:0] clamp;

    assign sq_full = v4_reg * v4_reg;

    // Curve stage. The soft clip knee is worked out at six guard bits
    // above the sample width, then saturated, halved and scaled by four.
    always_comb
    begin
        vw     = WB'(v5_reg);
        sqw    = WB'(signed'({1'b0, sq5_reg}));
        w_knee = '0;
        w_sat  = '0;
        clamp  = '0;
        s6_next = '0;
        case (curve)
            CURVE_HARD:
            begin
                if (v5_reg > C_EIGHTH)
                    clamp = C_EIGHTH;
                else if (v5_reg < -C_EIGHTH)
                    clamp = -C_EIGHTH;
                else
                    clamp = v5_reg;
                s6_next = times4(clamp);
            end
            CURVE_SOFT:
            begin
                if (v5_reg > C_SIXTH)
                    w_knee = W_QUARTER;
                else if (v5_reg > C_TWELFTH)
                    w_knee = W_QUARTER - W_THIRD + (vw <<< 2) - WB'(12) * sqw;
                else if (v5_reg < -C_SIXTH)
                    w_knee = -W_QUARTER;
                else if (v5_reg < -C_TWELFTH)
                    w_knee = W_THIRD - W_QUARTER + (vw <<< 2) + WB'(12) * sqw;
                else
                    w_knee = vw <<< 1;
                if (w_knee > W_MAX)
                    w_sat = S_MAX;
                else if (w_knee < W_MIN)
                    w_sat = S_MIN;
                else
                    w_sat = w_knee[SB-1:0];
                s6_next = times4(w_sat >>> 1);
            end
            CURVE_FULL:
            begin
                if (v5_reg == S_MIN)
                    clamp = S_MAX;
                else if (v5_reg < 0)
                    clamp = -v5_reg;
                else
                    clamp = v5_reg;
                s6_next = times4(clamp);
            end
            default:
            begin
                clamp   = (v5_reg > 0) ? v5_reg : '0;
                s6_next = times4(clamp);
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (load[0])
            p1_reg <= sample * lin_gain;
        if (load[1])
            l2_reg <= scale_sat(p1_reg);
        if (load[2])
        begin
            p3_reg <= l2_reg * drv_gain;
            l3_reg <= l2_reg;
        end
        if (load[3])
        begin
            v4_reg <= scale_sat(p3_reg);
            l4_reg <= l3_reg;
        end
        if (load[4])
        begin
            sq5_reg <= sq_full[PB-2:SB-1];
            v5_reg  <= v4_reg;
            l5_reg  <= l4_reg;
        end
        if (load[5])
        begin
            s6_reg <= s6_next;
            l6_reg <= l5_reg;
        end
    end

    assign gained = l6_reg;
    assign shaped = s6_reg;

endmodule

[rtl/gain_distortion_upmixer.sv]
// Top level of the stereo gain and distortion upmixer.
// Holds the configuration registers, pipeline control and output stage;
// instantiates two gdu_chan datapaths and uses gdu_pkg.
//
// The block takes one stereo frame per beat and returns one six-channel
// frame per beat. Both samples are scaled by the linear gain; in modes one
// and two each scaled sample is also scaled by the drive gain and shaped by
// the selected curve (hard clip, soft clip, full-wave or half-wave) to form
// the surround pair, and mode two adds a centre channel (left plus right)
// and an LFE channel (sum of the surrounds). Every product and sum
// saturates. The block accepts a new frame on every clock cycle unless the
// output side stalls it. From an accepted input beat to the matching
// output beat a frame passes two multiply and scale steps for each gain, a
// squaring multiplier and the curve stage in each channel, then the output
// register that forms centre and LFE. Each stage holds its own valid bit
// and moves on whenever the stage after it is empty or moving, so output
// stalls close up bubbles rather than losing or repeating frames, and an
// input beat is taken while a finished frame waits if a stage is empty.
// Configuration is written through a simple write port with no handshake
// and must only be changed while no frame is in flight.
module gain_distortion_upmixer #(
    parameter int SAMPLE_BITS = gdu_pkg::GDU_SAMPLE_BITS
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // Input beat.
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // Fields from bit 0: left_in [31:0], right_in [63:32].
    input  logic [gdu_pkg::GDU_IN_BITS-1:0]     s_tdata,
    // Output beat.
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // Fields from bit 0: left_out [31:0], right_out [63:32],
    // left_surround [95:64], right_surround [127:96], center_out [159:128],
    // lfe_out [191:160], channel_count [194:192], zero padding [199:195].
    output logic [gdu_pkg::GDU_OUT_BITS-1:0]    m_tdata,
    // Configuration write port.
    input  logic                                cfg_we,
    input  logic [1:0]                          cfg_index,
    input  logic [31:0]                         cfg_data
);
    import gdu_pkg::*;

    localparam int SB = SAMPLE_BITS;
    localparam int FB = GDU_FIELD_BITS;
    localparam int NS = GDU_STAGES;

    localparam logic signed [SB-1:0] S_MAX = {1'b0, {(SB-1){1'b1}}};
    localparam logic signed [SB-1:0] S_MIN = {1'b1, {(SB-1){1'b0}}};

    // Configuration registers.
    logic [1:0]  mode_reg;
    logic [1:0]  curve_reg;
    logic [31:0] lin_gain_reg;
    logic [31:0] drv_gain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg     <= MODE_STEREO;
            curve_reg    <= CURVE_HARD;
            lin_gain_reg <= GDU_RESET_LIN_GAIN;
            drv_gain_reg <= GDU_RESET_DRV_GAIN;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                GDU_REG_MODE:     mode_reg     <= cfg_data[1:0];
                GDU_REG_CURVE:    curve_reg    <= cfg_data[1:0];
                GDU_REG_LIN_GAIN: lin_gain_reg <= cfg_data;
                GDU_REG_DRV_GAIN: drv_gain_reg <= cfg_data;
                default:          mode_reg     <= mode_reg;
            endcase
        end
    end

    // Pipeline control. Stage k loads when it is empty or its successor
    // loads; the output register loads when empty or being taken.
    logic [NS-1:0] vld_reg;
    logic [NS-1:0] vld_next;
    logic [NS-1:0] load;
    logic          out_load;
    logic          m_tvalid_reg;

    always_comb
    begin
        out_load = !m_tvalid_reg || m_tready;
        load[NS-1] = !vld_reg[NS-1] || out_load;
        for (int k = NS - 2; k >= 0; k--)
            load[k] = !vld_reg[k] || load[k+1];
        vld_next[0] = load[0] ? s_tvalid : vld_reg[0];
        for (int k = 1; k < NS; k++)
            vld_next[k] = load[k] ? vld_reg[k-1] : vld_reg[k];
    end

    assign s_tready = load[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= vld_next;
            if (out_load)
                m_tvalid_reg <= vld_reg[NS-1];
        end
    end

    // Channel datapaths.
    logic signed [SB-1:0] left_gained;
    logic signed [SB-1:0] right_gained;
    logic signed [SB-1:0] left_shaped;
    logic signed [SB-1:0] right_shaped;

    gdu_chan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_left (
        .clk      (clk),
        .load     (load),
        .curve    (curve_t'(curve_reg)),
        .lin_gain (lin_gain_reg[SB-1:0]),
        .drv_gain (drv_gain_reg[SB-1:0]),
        .sample   (s_tdata[SB-1:0]),
        .gained   (left_gained),
        .shaped   (left_shaped)
    );

    gdu_chan #(
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_right (
        .clk      (clk),
        .load     (load),
        .curve    (curve_t'(curve_reg)),
        .lin_gain (lin_gain_reg[SB-1:0]),
        .drv_gain (drv_gain_reg[SB-1:0]),
        .sample   (s_tdata[FB+SB-1:FB]),
        .gained   (right_gained),
        .shaped   (right_shaped)
    );

    // Output stage: centre and LFE sums, mode gating and channel count.
    logic signed [SB:0]   center_sum;
    logic signed [SB:0]   lfe_sum;
    logic signed [SB-1:0] center_next;
    logic signed [SB-1:0] lfe_next;
    logic signed [SB-1:0] ls_next;
    logic signed [SB-1:0] rs_next;
    logic [2:0]           count_next;

    always_comb
    begin
        center_sum = (SB+1)'(left_gained) + (SB+1)'(right_gained);
        lfe_sum    = (SB+1)'(left_shaped) + (SB+1)'(right_shaped);
        center_next = '0;
        lfe_next    = '0;
        ls_next     = '0;
        rs_next     = '0;
        count_next  = GDU_COUNT_STEREO;
        unique case (mode_reg)
            MODE_QUAD:
            begin
                ls_next    = left_shaped;
                rs_next    = right_shaped;
                count_next = GDU_COUNT_QUAD;
            end
            MODE_SURROUND:
            begin
                ls_next    = left_shaped;
                rs_next    = right_shaped;
                count_next = GDU_COUNT_SURROUND;
                if (center_sum[SB] == center_sum[SB-1])
                    center_next = center_sum[SB-1:0];
                else
                    center_next = center_sum[SB] ? S_MIN : S_MAX;
                if (lfe_sum[SB] == lfe_sum[SB-1])
                    lfe_next = lfe_sum[SB-1:0];
                else
                    lfe_next = lfe_sum[SB] ? S_MIN : S_MAX;
            end
            default:
            begin
                count_next = GDU_COUNT_STEREO;
            end
        endcase
    end

    logic signed [SB-1:0] left_out_reg;
    logic signed [SB-1:0] right_out_reg;
    logic signed [SB-1:0] ls_out_reg;
    logic signed [SB-1:0] rs_out_reg;
    logic signed [SB-1:0] center_out_reg;
    logic signed [SB-1:0] lfe_out_reg;
    logic [2:0]           count_out_reg;

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            left_out_reg   <= left_gained;
            right_out_reg  <= right_gained;
            ls_out_reg     <= ls_next;
            rs_out_reg     <= rs_next;
            center_out_reg <= center_next;
            lfe_out_reg    <= lfe_next;
            count_out_reg  <= count_next;
        end
    end

    assign m_tvalid = m_tvalid_reg;

    // Samples are sign-extended to the 32-bit fields.
    assign m_tdata[FB-1:0]      = FB'(left_out_reg);
    assign m_tdata[2*FB-1:FB]   = FB'(right_out_reg);
    assign m_tdata[3*FB-1:2*FB] = FB'(ls_out_reg);
    assign m_tdata[4*FB-1:3*FB] = FB'(rs_out_reg);
    assign m_tdata[5*FB-1:4*FB] = FB'(center_out_reg);
    assign m_tdata[6*FB-1:5*FB] = FB'(lfe_out_reg);
    assign m_tdata[6*FB+GDU_COUNT_BITS-1:6*FB] = count_out_reg;
    assign m_tdata[GDU_OUT_BITS-1:GDU_OUT_RAW] = '0;

endmodule
